### hdl/dhfk_pkg.sv
package dhfk_pkg;

    localparam int BINS_X_DEF     = 8;
    localparam int BINS_Y_DEF     = 8;
    localparam int BINS_Z_DEF     = 8;
    localparam int COUNT_BITS_DEF = 32;

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(32'sh26DD3B6A);
    localparam logic signed [31:0]   ONE_Q30     = 32'sh4000_0000;

    localparam int PADDR_W  = 5;
    localparam int NUM_REGS = 6;
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MAX_X = 3'd1;
    localparam logic [2:0] REG_MIN_Y = 3'd2;
    localparam logic [2:0] REG_MAX_Y = 3'd3;
    localparam logic [2:0] REG_MIN_Z = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] link_length;
        logic [15:0]        link_twist;
        logic signed [31:0] link_offset;
        logic [15:0]        joint_angle;
        logic               last_link;
        logic [2:0]         read_index_x;
        logic [2:0]         read_index_y;
        logic [2:0]         read_index_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic               hit;
        logic [2:0]         bin_x;
        logic [2:0]         bin_y;
        logic [2:0]         bin_z;
        logic [31:0]        bin_count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CORDIC, ST_CFIN, ST_TMUL, ST_PRD, ST_MAC,
        ST_BPREP, ST_BDIV, ST_BFIN, ST_RDCMD, ST_HADDR, ST_HRD, ST_HWR, ST_OUT
    } state_t;

    function automatic logic signed [CW-1:0] atan_of(input logic [STEP_W-1:0] i);
        logic signed [CW-1:0] r;
        unique case (i)
            5'd0:    r = 34'h20000000;
            5'd1:    r = 34'h12E4051E;
            5'd2:    r = 34'h09FB385B;
            5'd3:    r = 34'h051111D4;
            5'd4:    r = 34'h028B0D43;
            5'd5:    r = 34'h0145D7E1;
            5'd6:    r = 34'h00A2F61E;
            5'd7:    r = 34'h00517C55;
            5'd8:    r = 34'h0028BE53;
            5'd9:    r = 34'h00145F2F;
            5'd10:   r = 34'h000A2F98;
            5'd11:   r = 34'h000517CC;
            5'd12:   r = 34'h00028BE6;
            5'd13:   r = 34'h000145F3;
            5'd14:   r = 34'h0000A2FA;
            5'd15:   r = 34'h0000517D;
            5'd16:   r = 34'h000028BE;
            5'd17:   r = 34'h0000145F;
            5'd18:   r = 34'h00000A30;
            5'd19:   r = 34'h00000518;
            5'd20:   r = 34'h0000028C;
            5'd21:   r = 34'h00000146;
            5'd22:   r = 34'h000000A3;
            5'd23:   r = 34'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // round half up at bit 30
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd536870912;
        return s[63:30];
    endfunction

endpackage

### hdl/dh_forward_kinematics_binner_unit.sv
// DH forward kinematics with a 3-D workspace histogram.
// Input words (s_valid/s_ready) are either one link's DH parameters or a bin read.
// Link words update a running pose (memory of 12 entries) with one shared
// 32x32 multiplier: a two-lane CORDIC, the link transform, then 4 reads plus 12
// multiply-accumulates per pose row. The next word is accepted only once a link
// word is through. The last link of a chain adds restoring division for the
// bin index (one quotient bit per cycle, three axes in parallel) and, on a hit,
// a read-modify-write of the histogram memory; the pose returns to identity.
// Results leave through an output register (m_valid/m_ready); a new word is taken
// while a result still waits, and the block only stalls when the next result is
// ready and the register is still full.
// After reset all BINS_X*BINS_Y*BINS_Z entries (512 by default) of the histogram
// memory are swept to zero, one entry a cycle, while s_ready stays low. Bounds are
// written through the APB port, by the user only while idle; the block won't check.
module dh_forward_kinematics_binner_unit #(
    parameter int BINS_X     = dhfk_pkg::BINS_X_DEF,
    parameter int BINS_Y     = dhfk_pkg::BINS_Y_DEF,
    parameter int BINS_Z     = dhfk_pkg::BINS_Z_DEF,
    parameter int COUNT_BITS = dhfk_pkg::COUNT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  dhfk_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output dhfk_pkg::out_item_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dhfk_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import dhfk_pkg::*;

    localparam int HIST_SIZE = BINS_X * BINS_Y * BINS_Z;
    localparam int HA_W      = (HIST_SIZE > 1) ? $clog2(HIST_SIZE) : 1;
    localparam int BMAX_XY   = (BINS_X > BINS_Y) ? BINS_X : BINS_Y;
    localparam int BMAX      = (BMAX_XY > BINS_Z) ? BMAX_XY : BINS_Z;
    localparam int QB        = $clog2(BMAX + 1);
    localparam int BW        = (QB > 3) ? QB : 3;
    localparam int DV_W      = 32 + QB;
    localparam int BINS_A [3] = '{BINS_X, BINS_Y, BINS_Z};

    // control
    state_t            state_reg, state_next;
    logic [HA_W-1:0]   clr_reg;
    logic              m_valid_reg;
    logic              pose_ident_reg;
    out_item_t         m_data_reg;

    // configuration
    logic signed [31:0] cfg_reg [NUM_REGS];

    // item and sequencing
    in_item_t           in_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [1:0]         r_reg, k_reg, j_reg;
    logic               iss_reg;
    logic               d_v_reg;
    logic [1:0]         d_k_reg, d_j_reg;
    logic [2:0]         d_t_reg;

    // cordic lanes: 0 theta, 1 alpha
    logic signed [CW-1:0] cx_reg [2];
    logic signed [CW-1:0] cy_reg [2];
    logic signed [CW-1:0] cz_reg [2];
    logic                 cneg_reg [2];

    logic signed [31:0] t_reg [12];
    logic signed [31:0] prow_reg [4];
    logic signed [35:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] pos_reg [3];

    // binning lanes
    logic [DV_W-1:0]    rem_reg [3];
    logic [31:0]        den_reg [3];
    logic               zden_reg [3];
    logic               miss_reg [3];
    logic [BW-1:0]      q_reg [3];
    logic [BW-1:0]      b_reg [3];
    logic               hit_reg;
    logic               rd_ok_reg;
    logic [HA_W-1:0]    h_addr_reg;
    logic [COUNT_BITS-1:0] cnt_reg;

    // memories
    logic signed [31:0]    pose_mem [12];
    logic signed [31:0]    pose_rdata_reg;
    logic [COUNT_BITS-1:0] hist_mem [HIST_SIZE];
    logic [COUNT_BITS-1:0] hist_rdata_reg;

    // combinational
    logic signed [31:0]    mul_a, mul_b;
    logic [3:0]            pose_raddr, pose_waddr;
    logic                  pose_we;
    logic signed [31:0]    pose_wdata;
    logic                  hist_we;
    logic [HA_W-1:0]       hist_waddr;
    logic [COUNT_BITS-1:0] hist_wdata;
    logic [COUNT_BITS-1:0] hist_inc;
    logic signed [33:0]    prod_rnd;
    logic signed [35:0]    mac_sum;
    logic signed [31:0]    mac_out;
    logic                  row_done;
    logic [DV_W-1:0]       num_c [3];
    logic [31:0]           den_c [3];
    logic                  miss_c [3];
    logic                  zden_c [3];
    logic [BW-1:0]         qclamp_c [3];
    logic [1:0]            prd_col;
    logic                  out_free;
    logic [2:0]            wr_idx, rd_idx;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign pready   = 1'b1;
    assign out_free = !m_valid_reg || m_ready;
    assign wr_idx   = paddr[4:2];
    assign rd_idx   = paddr[4:2];
    assign prd_col  = 2'(step_reg - STEP_W'(1));

    always_comb begin
        prdata = '0;
        if (rd_idx < 3'(NUM_REGS)) begin
            prdata = cfg_reg[rd_idx];
        end
    end

    // shared multiplier datapath
    assign prod_rnd = rnd30(prod_reg);
    assign mac_sum  = acc_reg + 36'(prod_rnd);
    assign mac_out  = sat32(64'(mac_sum) + ((d_k_reg == 2'd3) ? 64'(prow_reg[3]) : 64'sd0));
    assign row_done = d_v_reg && (d_k_reg == 2'd3) && (d_j_reg == 2'd2);
    assign hist_inc = (&hist_rdata_reg) ? hist_rdata_reg : hist_rdata_reg + COUNT_BITS'(1);

    // binning lanes
    always_comb begin
        logic signed [31:0] lo, hi;
        logic signed [32:0] diff;
        for (int a = 0; a < 3; a++) begin
            lo        = cfg_reg[2*a];
            hi        = cfg_reg[2*a+1];
            miss_c[a] = (pos_reg[a] < lo) || (pos_reg[a] > hi);
            zden_c[a] = (hi == lo);
            diff      = 33'(pos_reg[a]) - 33'(lo);
            den_c[a]  = 32'(hi - lo);
            num_c[a]  = DV_W'(diff[31:0]) * DV_W'(BINS_A[a]);
            if (zden_reg[a]) begin
                qclamp_c[a] = '0;
            end else if (q_reg[a] > BW'(BINS_A[a] - 1)) begin
                qclamp_c[a] = BW'(BINS_A[a] - 1);
            end else begin
                qclamp_c[a] = q_reg[a];
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == HA_W'(HIST_SIZE - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_valid) state_next = s_data.cmd ? ST_RDCMD : ST_CORDIC;
            ST_CORDIC: if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_CFIN;
            ST_CFIN:   state_next = ST_TMUL;
            ST_TMUL:   if (step_reg == STEP_W'(6)) state_next = ST_PRD;
            ST_PRD:    if (step_reg == STEP_W'(4)) state_next = ST_MAC;
            ST_MAC: begin
                if (row_done) begin
                    if (r_reg != 2'd2) begin
                        state_next = ST_PRD;
                    end else begin
                        state_next = in_reg.last_link ? ST_BPREP : ST_IDLE;
                    end
                end
            end
            ST_BPREP:  state_next = ST_BDIV;
            ST_BDIV:   if (step_reg == '0) state_next = ST_BFIN;
            ST_BFIN: begin
                if (miss_reg[0] || miss_reg[1] || miss_reg[2]) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_HADDR;
                end
            end
            ST_RDCMD:  state_next = ST_HADDR;
            ST_HADDR:  state_next = ST_HRD;
            ST_HRD:    state_next = ST_HWR;
            ST_HWR:    state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // multiplier operands and memory ports
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        pose_raddr = {r_reg, step_reg[1:0]};
        pose_we    = 1'b0;
        pose_waddr = {r_reg, d_k_reg};
        pose_wdata = mac_out;
        hist_we    = 1'b0;
        hist_waddr = h_addr_reg;
        hist_wdata = hist_inc;
        unique case (state_reg)
            ST_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = clr_reg;
                hist_wdata = '0;
            end
            ST_TMUL: begin
                unique case (step_reg[2:0])
                    3'd0: begin mul_a = t_reg[4];           mul_b = t_reg[10]; end
                    3'd1: begin mul_a = t_reg[4];           mul_b = t_reg[9];  end
                    3'd2: begin mul_a = in_reg.link_length; mul_b = t_reg[0];  end
                    3'd3: begin mul_a = t_reg[0];           mul_b = t_reg[10]; end
                    3'd4: begin mul_a = t_reg[0];           mul_b = t_reg[9];  end
                    3'd5: begin mul_a = in_reg.link_length; mul_b = t_reg[4];  end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_MAC: begin
                mul_a   = prow_reg[j_reg];
                mul_b   = t_reg[{j_reg, k_reg}];
                pose_we = d_v_reg && (d_j_reg == 2'd2);
            end
            ST_HWR: hist_we = !in_reg.cmd;
            default: begin
            end
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (pose_we) begin
            pose_mem[pose_waddr] <= pose_wdata;
        end
        pose_rdata_reg <= pose_mem[pose_raddr];
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rdata_reg <= hist_mem[h_addr_reg];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
            pose_ident_reg <= 1'b1;
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= (i % 2 == 0) ? -32'sd655360 : 32'sd655360;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + HA_W'(1);
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end
            if (state_reg == ST_MAC && row_done && r_reg == 2'd2) begin
                pose_ident_reg <= in_reg.last_link;
            end
            if (psel && penable && pwrite && wr_idx < 3'(NUM_REGS)) begin
                cfg_reg[wr_idx] <= pwdata;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        logic [31:0]        u;
        logic               ng;
        logic signed [CW-1:0] nx, ny;
        logic [15:0]        ang;
        prod_reg <= mul_a * mul_b;
        d_v_reg  <= (state_reg == ST_TMUL && step_reg < STEP_W'(6))
                    || (state_reg == ST_MAC && iss_reg);
        d_t_reg  <= step_reg[2:0];
        d_k_reg  <= k_reg;
        d_j_reg  <= j_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_reg   <= s_data;
                step_reg <= '0;
                r_reg    <= '0;
                for (int l = 0; l < 2; l++) begin
                    ang = (l == 0) ? s_data.joint_angle : s_data.link_twist;
                    u   = {ang, 16'h0000};
                    ng  = u[31] ^ u[30];
                    if (ng) begin
                        u[31] = ~u[31];
                    end
                    cx_reg[l]   <= CORDIC_GAIN;
                    cy_reg[l]   <= '0;
                    cz_reg[l]   <= CW'(signed'(u));
                    cneg_reg[l] <= ng;
                end
            end
            ST_CORDIC: begin
                step_reg <= step_reg + STEP_W'(1);
                for (int l = 0; l < 2; l++) begin
                    if (!cz_reg[l][CW-1]) begin
                        cx_reg[l] <= cx_reg[l] - (cy_reg[l] >>> step_reg);
                        cy_reg[l] <= cy_reg[l] + (cx_reg[l] >>> step_reg);
                        cz_reg[l] <= cz_reg[l] - atan_of(step_reg);
                    end else begin
                        cx_reg[l] <= cx_reg[l] + (cy_reg[l] >>> step_reg);
                        cy_reg[l] <= cy_reg[l] - (cx_reg[l] >>> step_reg);
                        cz_reg[l] <= cz_reg[l] + atan_of(step_reg);
                    end
                end
            end
            ST_CFIN: begin
                step_reg <= '0;
                nx = cneg_reg[0] ? -cx_reg[0] : cx_reg[0];
                ny = cneg_reg[0] ? -cy_reg[0] : cy_reg[0];
                t_reg[0] <= sat32(64'(nx));
                t_reg[4] <= sat32(64'(ny));
                nx = cneg_reg[1] ? -cx_reg[1] : cx_reg[1];
                ny = cneg_reg[1] ? -cy_reg[1] : cy_reg[1];
                t_reg[10] <= sat32(64'(nx));
                t_reg[9]  <= sat32(64'(ny));
                t_reg[8]  <= '0;
                t_reg[11] <= in_reg.link_offset;
            end
            ST_TMUL: begin
                step_reg <= (step_reg == STEP_W'(6)) ? '0 : step_reg + STEP_W'(1);
                if (d_v_reg) begin
                    unique case (d_t_reg)
                        3'd0: t_reg[1] <= sat32(-64'(prod_rnd));
                        3'd1: t_reg[2] <= sat32(64'(prod_rnd));
                        3'd2: t_reg[3] <= sat32(64'(prod_rnd));
                        3'd3: t_reg[5] <= sat32(64'(prod_rnd));
                        3'd4: t_reg[6] <= sat32(-64'(prod_rnd));
                        3'd5: t_reg[7] <= sat32(64'(prod_rnd));
                        default: begin
                        end
                    endcase
                end
            end
            ST_PRD: begin
                if (step_reg != '0) begin
                    // identity until the whole pose has been written once, and again after a last link
                    if (pose_ident_reg) begin
                        prow_reg[prd_col] <= (prd_col == r_reg) ? ONE_Q30 : '0;
                    end else begin
                        prow_reg[prd_col] <= pose_rdata_reg;
                    end
                end
                step_reg <= (step_reg == STEP_W'(4)) ? '0 : step_reg + STEP_W'(1);
                iss_reg  <= 1'b1;
                k_reg    <= '0;
                j_reg    <= '0;
                acc_reg  <= '0;
            end
            ST_MAC: begin
                if (iss_reg) begin
                    if (j_reg == 2'd2) begin
                        j_reg <= '0;
                        k_reg <= k_reg + 2'd1;
                        if (k_reg == 2'd3) begin
                            iss_reg <= 1'b0;
                        end
                    end else begin
                        j_reg <= j_reg + 2'd1;
                    end
                end
                if (d_v_reg) begin
                    if (d_j_reg == 2'd2) begin
                        acc_reg <= '0;
                        if (d_k_reg == 2'd3) begin
                            pos_reg[r_reg] <= mac_out;
                        end
                    end else begin
                        acc_reg <= mac_sum;
                    end
                end
                if (row_done) begin
                    r_reg <= r_reg + 2'd1;
                end
            end
            ST_BPREP: begin
                step_reg <= STEP_W'(QB - 1);
                for (int a = 0; a < 3; a++) begin
                    rem_reg[a]  <= num_c[a];
                    den_reg[a]  <= den_c[a];
                    zden_reg[a] <= zden_c[a];
                    miss_reg[a] <= miss_c[a];
                    q_reg[a]    <= '0;
                end
            end
            ST_BDIV: begin
                step_reg <= step_reg - STEP_W'(1);
                for (int a = 0; a < 3; a++) begin
                    if (rem_reg[a] >= (DV_W'(den_reg[a]) << step_reg)) begin
                        rem_reg[a] <= rem_reg[a] - (DV_W'(den_reg[a]) << step_reg);
                        q_reg[a]   <= q_reg[a] | (BW'(1) << step_reg);
                    end
                end
            end
            ST_BFIN: begin
                hit_reg <= !(miss_reg[0] || miss_reg[1] || miss_reg[2]);
                cnt_reg <= '0;
                for (int a = 0; a < 3; a++) begin
                    b_reg[a] <= qclamp_c[a];
                end
            end
            ST_RDCMD: begin
                hit_reg   <= 1'b0;
                b_reg[0]  <= BW'(in_reg.read_index_x);
                b_reg[1]  <= BW'(in_reg.read_index_y);
                b_reg[2]  <= BW'(in_reg.read_index_z);
                rd_ok_reg <= (int'(in_reg.read_index_x) < BINS_X)
                             && (int'(in_reg.read_index_y) < BINS_Y)
                             && (int'(in_reg.read_index_z) < BINS_Z);
            end
            ST_HADDR: begin
                h_addr_reg <= HA_W'((int'(b_reg[0]) * BINS_Y + int'(b_reg[1])) * BINS_Z
                                    + int'(b_reg[2]));
            end
            ST_HWR: begin
                if (in_reg.cmd) begin
                    cnt_reg <= rd_ok_reg ? hist_rdata_reg : '0;
                end else begin
                    cnt_reg <= hist_inc;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_reg.end_x     <= in_reg.cmd ? '0 : pos_reg[0];
                    m_data_reg.end_y     <= in_reg.cmd ? '0 : pos_reg[1];
                    m_data_reg.end_z     <= in_reg.cmd ? '0 : pos_reg[2];
                    m_data_reg.hit       <= hit_reg;
                    m_data_reg.bin_x     <= (hit_reg || in_reg.cmd) ? 3'(b_reg[0]) : '0;
                    m_data_reg.bin_y     <= (hit_reg || in_reg.cmd) ? 3'(b_reg[1]) : '0;
                    m_data_reg.bin_z     <= (hit_reg || in_reg.cmd) ? 3'(b_reg[2]) : '0;
                    m_data_reg.bin_count <= 32'(cnt_reg);
                end
            end
            default: begin
            end
        endcase
    end

    a_out_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result word appeared outside the output state");

    a_ident_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC && state_next == ST_BPREP) |=> pose_ident_reg)
        else $error("pose not returned to identity after last link");

    a_hist_rmw_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HWR) |-> $past(state_reg == ST_HRD))
        else $error("histogram update without a preceding read");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CORDIC || state_reg == ST_RDCMD))
        else $error("accepted word did not start work");

endmodule

### tb/dh_forward_kinematics_binner_unit_tb.sv
`timescale 1ns / 1ps

module dh_forward_kinematics_binner_unit_tb;
    import dhfk_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd6;   // decodes to nothing
    localparam int Q_ONE = 65536;
    localparam int SEG_ITEMS = 390;
    localparam int DRAIN_CYCLES = 200;

    class kin_scoreboard;
        longint bound[6];
        longint pose[12];
        longint unsigned bin_hits[512];
        out_item_t pending_q[$];
        int n_err, n_pos, n_hit, n_read;
        longint atan_lut[24] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
            'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

        function new();
            for (int i = 0; i < 6; i++) bound[i] = (i % 2) ? 655360 : -655360;
            foreach (bin_hits[i]) bin_hits[i] = 0;
            pose_to_identity();
        endfunction

        function void pose_to_identity();
            foreach (pose[i]) pose[i] = 0;
            pose[0] = 64'sd1 <<< 30;
            pose[5] = 64'sd1 <<< 30;
            pose[10] = 64'sd1 <<< 30;
        endfunction

        function void set_bound(int idx, logic [31:0] val);
            if (idx < 6) bound[idx] = longint'(signed'(val));
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint qmul(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function void cordic(logic [15:0] ang, output longint c, output longint s);
            logic [31:0] u;
            bit flip;
            longint x, y, z, t;
            u = {ang, 16'h0000};
            flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
            if (flip) u = u - 32'h8000_0000;
            z = longint'(signed'(u));
            x = 'h26DD3B6A;
            y = 0;
            for (int i = 0; i < 24; i++) begin
                if (z >= 0) begin
                    t = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
                end else begin
                    t = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
                end
                x = t;
            end
            if (flip) begin
                x = -x; y = -y;
            end
            c = clip32(x);
            s = clip32(y);
        endfunction

        function int which_bin(longint c, longint lo, longint hi);
            longint b;
            if (c < lo || c > hi) return -1;
            if (hi == lo) return 0;
            b = ((c - lo) * 8) / (hi - lo);
            if (b > 7) b = 7;
            return int'(b);
        endfunction

        function void note(in_item_t w);
            longint ct, st, ca, sa, a, acc;
            longint tf[12], np[12];
            int bx, by, bz, idx;
            out_item_t r;
            r = '0;
            if (w.cmd) begin
                idx = (int'(w.read_index_x) * 8 + int'(w.read_index_y)) * 8
                      + int'(w.read_index_z);
                r.bin_x = w.read_index_x;
                r.bin_y = w.read_index_y;
                r.bin_z = w.read_index_z;
                r.bin_count = bin_hits[idx][31:0];
                pending_q.push_back(r);
                n_read++;
                return;
            end
            a = longint'(w.link_length);
            cordic(w.joint_angle, ct, st);
            cordic(w.link_twist, ca, sa);
            tf[0] = ct;               tf[1] = clip32(-qmul(st, ca));
            tf[2] = clip32(qmul(st, sa)); tf[3] = clip32(qmul(a, ct));
            tf[4] = st;               tf[5] = clip32(qmul(ct, ca));
            tf[6] = clip32(-qmul(ct, sa)); tf[7] = clip32(qmul(a, st));
            tf[8] = 0;                tf[9] = sa;
            tf[10] = ca;              tf[11] = longint'(w.link_offset);
            for (int row = 0; row < 3; row++) begin
                for (int k = 0; k < 4; k++) begin
                    acc = qmul(pose[row*4], tf[k]) + qmul(pose[row*4+1], tf[4+k])
                          + qmul(pose[row*4+2], tf[8+k]);
                    if (k == 3) acc += pose[row*4+3];
                    np[row*4+k] = clip32(acc);
                end
            end
            pose = np;
            if (!w.last_link) return;
            r.end_x = pose[3][31:0];
            r.end_y = pose[7][31:0];
            r.end_z = pose[11][31:0];
            bx = which_bin(pose[3], bound[0], bound[1]);
            by = which_bin(pose[7], bound[2], bound[3]);
            bz = which_bin(pose[11], bound[4], bound[5]);
            pose_to_identity();
            n_pos++;
            if (bx >= 0 && by >= 0 && bz >= 0) begin
                idx = (bx * 8 + by) * 8 + bz;
                if (bin_hits[idx] < 64'hFFFF_FFFF) bin_hits[idx]++;
                r.hit = 1'b1;
                r.bin_x = bx[2:0];
                r.bin_y = by[2:0];
                r.bin_z = bz[2:0];
                r.bin_count = bin_hits[idx][31:0];
                n_hit++;
            end
            pending_q.push_back(r);
        endfunction

        function void check(out_item_t got);
            out_item_t exp_r;
            if (pending_q.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                n_err++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.end_x !== exp_r.end_x) begin
                $error("end_x: expected %0d, got %0d", exp_r.end_x, got.end_x); n_err++;
            end
            if (got.end_y !== exp_r.end_y) begin
                $error("end_y: expected %0d, got %0d", exp_r.end_y, got.end_y); n_err++;
            end
            if (got.end_z !== exp_r.end_z) begin
                $error("end_z: expected %0d, got %0d", exp_r.end_z, got.end_z); n_err++;
            end
            if (got.hit !== exp_r.hit) begin
                $error("hit: expected %0d, got %0d", exp_r.hit, got.hit); n_err++;
            end
            if (got.bin_x !== exp_r.bin_x) begin
                $error("bin_x: expected %0d, got %0d", exp_r.bin_x, got.bin_x); n_err++;
            end
            if (got.bin_y !== exp_r.bin_y) begin
                $error("bin_y: expected %0d, got %0d", exp_r.bin_y, got.bin_y); n_err++;
            end
            if (got.bin_z !== exp_r.bin_z) begin
                $error("bin_z: expected %0d, got %0d", exp_r.bin_z, got.bin_z); n_err++;
            end
            if (got.bin_count !== exp_r.bin_count) begin
                $error("bin_count: expected %0d, got %0d", exp_r.bin_count,
                       got.bin_count);
                n_err++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    kin_scoreboard sb = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int n_sent = 0;

    dh_forward_kinematics_binner_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check(m_data);
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_word(in_item_t w);
        @(negedge aclk);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note(w);
        n_sent++;
    endtask

    task automatic wait_drained();
        // the last word is already taken, so stop offering it
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic bound_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00}); pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_bound(int'(idx), val);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_bounds(int x0, int x1, int y0, int y1, int z0, int z1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        bound_write(REG_MIN_X, x0); bound_write(REG_MAX_X, x1);
        bound_write(REG_MIN_Y, y0); bound_write(REG_MAX_Y, y1);
        bound_write(REG_MIN_Z, z0); bound_write(REG_MAX_Z, z1);
    endtask

    function automatic in_item_t link_word(bit last, bit wild, bit zeroed);
        in_item_t w;
        w = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        w.cmd = 1'b0;
        w.last_link = last;
        if (zeroed) begin
            w.link_length = 0; w.link_offset = 0; w.link_twist = 0; w.joint_angle = 0;
        end else if (!wild) begin
            w.link_length = $signed($urandom_range(6 * Q_ONE)) - 3 * Q_ONE;
            w.link_offset = $signed($urandom_range(6 * Q_ONE)) - 3 * Q_ONE;
        end
        return w;
    endfunction

    function automatic in_item_t read_word(logic [2:0] ix, logic [2:0] iy, logic [2:0] iz);
        in_item_t w;
        w = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        w.cmd = 1'b1;
        w.read_index_x = ix; w.read_index_y = iy; w.read_index_z = iz;
        return w;
    endfunction

    task automatic single_offset(int d);
        in_item_t w;
        w = link_word(1'b1, 1'b0, 1'b1);
        w.link_offset = d;
        send_word(w);
    endtask

    task automatic random_segment(int n_items, bit with_pause);
        int links;
        bit wild, zeroed;
        int start;
        start = n_sent;
        while (n_sent - start < n_items) begin
            if (with_pause && n_sent - start > n_items / 2) begin
                // let everything drain before carrying on
                wait_drained();
                with_pause = 0;
            end
            if ($urandom_range(99) < 15) begin
                send_word(read_word(3'($urandom), 3'($urandom), 3'($urandom)));
            end else begin
                links = $urandom_range(4, 1);
                wild = ($urandom_range(99) < 8);
                zeroed = ($urandom_range(99) < 6);
                for (int i = 1; i <= links; i++)
                    send_word(link_word(i == links, wild, zeroed));
            end
        end
    endtask

    initial begin
        in_item_t w;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed words under reset bounds
        bound_write(REG_SPARE, 32'h1234_5678);
        send_word(read_word(3'd0, 3'd0, 3'd0));
        send_word(read_word(3'd7, 3'd7, 3'd7));
        single_offset(655360);
        single_offset(655361);
        single_offset(-655360);
        single_offset(-655361);
        send_word(link_word(1'b1, 1'b0, 1'b1));
        w = link_word(1'b0, 1'b0, 1'b0);
        w.link_length = 32'sh7FFF_FFFF; w.link_offset = 32'sh8000_0000;
        w.link_twist = 16'hFFFF; w.joint_angle = 16'h8000;
        send_word(w);
        w.link_twist = 16'h4000; w.joint_angle = 16'hC000;
        w.link_length = 32'sh8000_0000; w.link_offset = 32'sh7FFF_FFFF;
        send_word(w);
        w.last_link = 1'b1; w.link_twist = 16'h0000; w.joint_angle = 16'h4000;
        send_word(w);
        for (int i = 1; i <= 3; i++) send_word(link_word(i == 3, 1'b1, 1'b0));
        send_word(read_word(3'd4, 3'd4, 3'd7));
        send_word(read_word(3'd4, 3'd4, 3'd0));
        send_word(read_word(3'd4, 3'd4, 3'd4));

        random_segment(SEG_ITEMS, 1'b0);

        src_idle_pct = 64;
        set_bounds(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF);
        random_segment(SEG_ITEMS, 1'b1);

        src_idle_pct = 0; sink_stall_pct = 64;
        set_bounds(0, 0, -4 * Q_ONE, 4 * Q_ONE, -4 * Q_ONE, 4 * Q_ONE);
        random_segment(SEG_ITEMS, 1'b0);

        src_idle_pct = 38; sink_stall_pct = 38;
        // z range reversed: nothing can be counted
        set_bounds(-5 * Q_ONE, 5 * Q_ONE, 0, 10 * Q_ONE, 10 * Q_ONE, -10 * Q_ONE);
        random_segment(SEG_ITEMS, 1'b0);

        set_bounds(-Q_ONE, 7 * Q_ONE, -10 * Q_ONE, 10 * Q_ONE, -10 * Q_ONE, 10 * Q_ONE);
        random_segment(SEG_ITEMS, 1'b0);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d words: %0d end positions (%0d counted), %0d bin reads",
                 n_sent, sb.n_pos, sb.n_hit, sb.n_read);
        $display("bound settings: reset, full range, empty x, reversed z, offset window");
        if (sb.n_err == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
